// ===== src/tick_signal_order_engine_unit_assert.svh =====
// assertion macros for the tick signal order engine
`ifndef TICK_SIGNAL_ORDER_ENGINE_UNIT_ASSERT_SVH
`define TICK_SIGNAL_ORDER_ENGINE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define TSOE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("tsoe assertion failed");
// next-cycle implication
`define TSOE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("tsoe assertion failed");
`else
`define TSOE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSOE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/tsoe_pkg.sv =====
`timescale 1ns / 1ps
package tsoe_pkg;

	localparam int PRICE_W    = 24;
	localparam int INST_W     = 4;
	localparam int COUNT_W    = 32;
	localparam int LIMIT_W    = 24;
	localparam int DEV_W      = 7;
	localparam int OFFSET_W   = 16;
	localparam int MINH_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int PCT_SCALE = 100;

	localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

	localparam logic [LIMIT_W-1:0]  LOW_LIMIT_RST  = 24'd10500;
	localparam logic [LIMIT_W-1:0]  HIGH_LIMIT_RST = 24'd19500;
	localparam logic [DEV_W-1:0]    DEV_PCT_RST    = 7'd2;
	localparam logic [OFFSET_W-1:0] OFFSET_RST     = 16'd1;
	localparam logic [MINH_W-1:0]   MIN_HIST_RST   = 4'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_LIMIT  = 3'd0,
		REG_HIGH_LIMIT = 3'd1,
		REG_DEV_PCT    = 3'd2,
		REG_OFFSET     = 3'd3,
		REG_MIN_HIST   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [LIMIT_W-1:0]  low_limit;
		logic [LIMIT_W-1:0]  high_limit;
		logic [DEV_W-1:0]    dev_pct;
		logic [OFFSET_W-1:0] offset;
		logic [MINH_W-1:0]   min_hist;
	} cfg_t;

	typedef struct packed {
		logic [INST_W-1:0]  instrument;
		logic [PRICE_W-1:0] price;
	} tick_t;

	typedef struct packed {
		logic               order_valid;
		logic               order_is_buy;
		logic [INST_W-1:0]  order_instrument;
		logic [PRICE_W-1:0] order_price;
		logic               threshold_hit;
		logic               deviation_hit;
		logic               momentum_hit;
		logic [COUNT_W-1:0] threshold_count;
		logic [COUNT_W-1:0] deviation_count;
		logic [COUNT_W-1:0] momentum_count;
	} result_t;

	// per-beat flags handed from the window stage to the evaluation stage
	typedef struct packed {
		logic in_range;
		logic thr;
		logic mom;
	} sig_ctrl_t;

endpackage

// ===== src/tsoe_ram.sv =====
`timescale 1ns / 1ps
module tsoe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 160
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/tsoe_hist.sv =====
`timescale 1ns / 1ps
module tsoe_hist #(
	parameter int NUM_INSTRUMENTS = 16,
	parameter int WINDOW_DEPTH    = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tsoe_pkg::cfg_t             cfg,
	input  logic                       tick_valid,
	input  tsoe_pkg::tick_t            tick,
	output logic                       tick_stall,
	input  logic                       s2_take,
	output logic                       s2_valid,
	output tsoe_pkg::sig_ctrl_t        s2_ctrl,
	output logic [tsoe_pkg::INST_W-1:0]  s2_inst,
	output logic [tsoe_pkg::PRICE_W-1:0] s2_price,
	output logic [$clog2(WINDOW_DEPTH+1)-1:0] s2_fill,
	output logic [tsoe_pkg::PRICE_W+$clog2(WINDOW_DEPTH)-1:0] s2_sum,
	output logic [tsoe_pkg::PRICE_W+$clog2(WINDOW_DEPTH)-1:0] s2_pn
);

	// only 2**INST_W instruments can ever be addressed
	localparam int NI = (NUM_INSTRUMENTS < (1 << tsoe_pkg::INST_W)) ?
		NUM_INSTRUMENTS : (1 << tsoe_pkg::INST_W);
	localparam int IW = (NI > 1) ? $clog2(NI) : 1;
	localparam int HW = $clog2(WINDOW_DEPTH);
	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int PW = tsoe_pkg::PRICE_W;
	localparam int SW = PW + $clog2(WINDOW_DEPTH);
	localparam int MD = NI * WINDOW_DEPTH;
	localparam int AW = $clog2(MD);

	logic [HW-1:0] head_q  [NI];
	logic [FW-1:0] fill_q  [NI];
	logic [SW-1:0] sum_q   [NI];
	logic [PW-1:0] last1_q [NI];
	logic [PW-1:0] last2_q [NI];

	logic                        s1_v_q;
	logic                        s1_rng_s1;
	logic [tsoe_pkg::INST_W-1:0] s1_inst_s1;
	logic [PW-1:0]               s1_price_s1;
	logic [HW-1:0]               s1_head_s1;
	logic [AW-1:0]               s1_addr_s1;
	logic [PW-1:0]               old_s1;

	logic                        s2_v_q;
	tsoe_pkg::sig_ctrl_t         ctrl_s2;
	logic [tsoe_pkg::INST_W-1:0] inst_s2;
	logic [PW-1:0]               price_s2;
	logic [FW-1:0]               fill_s2;
	logic [SW-1:0]               sum_s2;
	logic [SW-1:0]               pn_s2;

	logic          s2_free, s1_free, s1_move, tick_acc;
	logic [IW-1:0] idx_in, idx_s1;
	logic          rng_in;
	logic [HW-1:0] head_next, head_fwd;
	logic [AW-1:0] rd_addr;

	logic [FW-1:0]      fill_old, fill_new;
	logic               full;
	logic [SW-1:0]      sum_new, pn;
	tsoe_pkg::sig_ctrl_t ctrl_s1;

	assign s2_free  = !s2_v_q || s2_take;
	assign s1_free  = !s1_v_q || s2_free;
	assign s1_move  = s1_v_q && s2_free;
	assign tick_acc = tick_valid && s1_free;
	assign tick_stall = !s1_free;

	assign idx_in = IW'(tick.instrument);
	assign rng_in = int'(tick.instrument) < NI;

	assign head_next = (s1_head_s1 == HW'(WINDOW_DEPTH - 1)) ? '0 : s1_head_s1 + 1'b1;

	// the beat leaving s1 updates the head at this same edge
	assign head_fwd = (s1_v_q && s1_inst_s1 == tick.instrument) ? head_next : head_q[idx_in];
	assign rd_addr  = AW'(idx_in) * AW'(WINDOW_DEPTH) + AW'(head_fwd);

	tsoe_ram #(
		.WIDTH (PW),
		.DEPTH (MD)
	) u_window (
		.clk     (clk),
		.wr_en   (s1_move && s1_rng_s1),
		.wr_addr (s1_addr_s1),
		.wr_data (s1_price_s1),
		.rd_en   (tick_acc),
		.rd_addr (rd_addr),
		.rd_data (old_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s1_free) begin
			s1_v_q <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			s1_rng_s1   <= rng_in;
			s1_inst_s1  <= tick.instrument;
			s1_price_s1 <= tick.price;
			s1_head_s1  <= head_fwd;
			s1_addr_s1  <= rd_addr;
		end
	end

	assign idx_s1   = IW'(s1_inst_s1);
	assign fill_old = fill_q[idx_s1];
	assign full     = (fill_old == FW'(WINDOW_DEPTH));

	always_comb begin
		fill_new = full ? FW'(WINDOW_DEPTH) : fill_old + 1'b1;
		sum_new  = sum_q[idx_s1] - (full ? SW'(old_s1) : '0) + SW'(s1_price_s1);
		pn       = SW'(s1_price_s1) * SW'(fill_new);
		ctrl_s1.in_range = s1_rng_s1;
		ctrl_s1.thr = s1_rng_s1 &&
			((s1_price_s1 < cfg.low_limit) || (s1_price_s1 > cfg.high_limit));
		// three rising prices: the current one over the last, the last over the one before it
		ctrl_s1.mom = s1_rng_s1 && (fill_new >= FW'(3)) &&
			(s1_price_s1 > last1_q[idx_s1]) && (last1_q[idx_s1] > last2_q[idx_s1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NI; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
				sum_q[i]  <= '0;
			end
		end else if (s1_move && s1_rng_s1) begin
			head_q[idx_s1] <= head_next;
			fill_q[idx_s1] <= fill_new;
			sum_q[idx_s1]  <= sum_new;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && s1_rng_s1) begin
			last1_q[idx_s1] <= s1_price_s1;
			last2_q[idx_s1] <= last1_q[idx_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else if (s2_free) begin
			s2_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			ctrl_s2  <= ctrl_s1;
			inst_s2  <= s1_inst_s1;
			price_s2 <= s1_price_s1;
			fill_s2  <= fill_new;
			sum_s2   <= sum_new;
			pn_s2    <= pn;
		end
	end

	assign s2_valid = s2_v_q;
	assign s2_ctrl  = ctrl_s2;
	assign s2_inst  = inst_s2;
	assign s2_price = price_s2;
	assign s2_fill  = fill_s2;
	assign s2_sum   = sum_s2;
	assign s2_pn    = pn_s2;

endmodule

// ===== src/tsoe_eval.sv =====
`timescale 1ns / 1ps
module tsoe_eval #(
	parameter int WINDOW_DEPTH = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tsoe_pkg::cfg_t             cfg,
	input  logic                       s2_valid,
	input  tsoe_pkg::sig_ctrl_t        s2_ctrl,
	input  logic [tsoe_pkg::INST_W-1:0]  s2_inst,
	input  logic [tsoe_pkg::PRICE_W-1:0] s2_price,
	input  logic [$clog2(WINDOW_DEPTH+1)-1:0] s2_fill,
	input  logic [tsoe_pkg::PRICE_W+$clog2(WINDOW_DEPTH)-1:0] s2_sum,
	input  logic [tsoe_pkg::PRICE_W+$clog2(WINDOW_DEPTH)-1:0] s2_pn,
	output logic                       s2_take,
	output logic                       result_valid,
	input  logic                       result_stall,
	output tsoe_pkg::result_t          result_data
);

	localparam int PW = tsoe_pkg::PRICE_W;
	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int SW = PW + $clog2(WINDOW_DEPTH);
	localparam int MW = SW + 8;
	localparam int CW = (FW > tsoe_pkg::MINH_W) ? FW : tsoe_pkg::MINH_W;
	localparam int NW = tsoe_pkg::COUNT_W;

	function automatic logic [NW-1:0] sat_inc(input logic [NW-1:0] c, input logic hit);
		logic [NW-1:0] r;
		r = (hit && c != '1) ? c + 1'b1 : c;
		return r;
	endfunction

	logic              out_v_q;
	tsoe_pkg::result_t out_q;
	logic [NW-1:0]     thr_cnt_q, dev_cnt_q, mom_cnt_q;
	logic [NW-1:0]     thr_cnt, dev_cnt, mom_cnt;

	logic              out_free, load;
	logic [7:0]        low_f, high_f;
	logic [MW-1:0]     lhs, low_b, high_b;
	logic              hist_ok, dev, below, buy, sell, valid;
	logic [PW:0]       up_sum;
	logic [PW-1:0]     buy_px, sell_px, off_px;
	tsoe_pkg::result_t res;

	assign out_free = !out_v_q || !result_stall;
	assign s2_take  = out_free;
	assign load     = s2_valid && out_free;

	always_comb begin
		// a band of 100 percent or more leaves no lower side
		low_f  = (cfg.dev_pct < 7'(tsoe_pkg::PCT_SCALE)) ?
			8'(tsoe_pkg::PCT_SCALE) - {1'b0, cfg.dev_pct} : '0;
		high_f = 8'(tsoe_pkg::PCT_SCALE) + {1'b0, cfg.dev_pct};
		// exact average compare: price*100*n against sum*(100 -/+ d)
		lhs    = MW'(s2_pn) * MW'(tsoe_pkg::PCT_SCALE);
		low_b  = MW'(s2_sum) * MW'(low_f);
		high_b = MW'(s2_sum) * MW'(high_f);
		hist_ok = CW'(s2_fill) >= CW'(cfg.min_hist);
		dev    = s2_ctrl.in_range && hist_ok && ((lhs < low_b) || (lhs > high_b));
		below  = s2_pn < s2_sum;
		buy    = s2_ctrl.thr || s2_ctrl.mom || (dev && below);
		sell   = dev && !below;
		valid  = buy || sell;

		off_px  = PW'(cfg.offset);
		up_sum  = {1'b0, s2_price} + {1'b0, off_px};
		buy_px  = up_sum[PW] ? tsoe_pkg::PRICE_MAX : up_sum[PW-1:0];
		sell_px = (s2_price > off_px) ? s2_price - off_px : '0;

		thr_cnt = sat_inc(thr_cnt_q, s2_ctrl.thr);
		dev_cnt = sat_inc(dev_cnt_q, dev);
		mom_cnt = sat_inc(mom_cnt_q, s2_ctrl.mom);

		res.order_valid      = valid;
		res.order_is_buy     = buy;
		res.order_instrument = valid ? s2_inst : '0;
		res.order_price      = buy ? buy_px : (sell ? sell_px : '0);
		res.threshold_hit    = s2_ctrl.thr;
		res.deviation_hit    = dev;
		res.momentum_hit     = s2_ctrl.mom;
		res.threshold_count  = thr_cnt;
		res.deviation_count  = dev_cnt;
		res.momentum_count   = mom_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			thr_cnt_q <= '0;
			dev_cnt_q <= '0;
			mom_cnt_q <= '0;
		end else begin
			if (out_free) begin
				out_v_q <= s2_valid;
			end
			if (load) begin
				thr_cnt_q <= thr_cnt;
				dev_cnt_q <= dev_cnt;
				mom_cnt_q <= mom_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign result_valid = out_v_q;
	assign result_data  = out_q;

endmodule

// ===== src/tick_signal_order_engine_unit.sv =====
`timescale 1ns / 1ps
// pipeline: a taken tick passes the window read, signal evaluation and result register
//   stages in that order before its result can be taken
// throughput: one tick per cycle unless result_stall backs up the pipeline, set by the
//   per-instrument fill/sum/head update and the head forwarded to the next window read
// reset: clears pipeline valids, per-instrument fill, head and sum, the signal counts and
//   the registers to their defaults; the price window memory is not cleared
`include "tick_signal_order_engine_unit_assert.svh"
module tick_signal_order_engine_unit #(
	parameter int NUM_INSTRUMENTS = 16,
	parameter int WINDOW_DEPTH    = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick_valid,
	output logic                              tick_stall,
	input  tsoe_pkg::tick_t                   tick_data,
	output logic                              result_valid,
	input  logic                              result_stall,
	output tsoe_pkg::result_t                 result_data,
	input  logic                              cfg_write,
	input  logic [tsoe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tsoe_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int PW = tsoe_pkg::PRICE_W;
	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int SW = PW + $clog2(WINDOW_DEPTH);

	tsoe_pkg::cfg_t cfg_q;

	logic                        s2_take, s2_valid;
	tsoe_pkg::sig_ctrl_t         s2_ctrl;
	logic [tsoe_pkg::INST_W-1:0] s2_inst;
	logic [PW-1:0]               s2_price;
	logic [FW-1:0]               s2_fill;
	logic [SW-1:0]               s2_sum;
	logic [SW-1:0]               s2_pn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_limit  <= tsoe_pkg::LOW_LIMIT_RST;
			cfg_q.high_limit <= tsoe_pkg::HIGH_LIMIT_RST;
			cfg_q.dev_pct    <= tsoe_pkg::DEV_PCT_RST;
			cfg_q.offset     <= tsoe_pkg::OFFSET_RST;
			cfg_q.min_hist   <= tsoe_pkg::MIN_HIST_RST;
		end else if (cfg_write) begin
			unique case (tsoe_pkg::cfg_reg_t'(cfg_index))
				tsoe_pkg::REG_LOW_LIMIT: begin
					cfg_q.low_limit <= cfg_data[tsoe_pkg::LIMIT_W-1:0];
				end
				tsoe_pkg::REG_HIGH_LIMIT: begin
					cfg_q.high_limit <= cfg_data[tsoe_pkg::LIMIT_W-1:0];
				end
				tsoe_pkg::REG_DEV_PCT: begin
					cfg_q.dev_pct <= cfg_data[tsoe_pkg::DEV_W-1:0];
				end
				tsoe_pkg::REG_OFFSET: begin
					cfg_q.offset <= cfg_data[tsoe_pkg::OFFSET_W-1:0];
				end
				tsoe_pkg::REG_MIN_HIST: begin
					cfg_q.min_hist <= cfg_data[tsoe_pkg::MINH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	tsoe_hist #(
		.NUM_INSTRUMENTS (NUM_INSTRUMENTS),
		.WINDOW_DEPTH    (WINDOW_DEPTH)
	) u_hist (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.tick_valid (tick_valid),
		.tick       (tick_data),
		.tick_stall (tick_stall),
		.s2_take    (s2_take),
		.s2_valid   (s2_valid),
		.s2_ctrl    (s2_ctrl),
		.s2_inst    (s2_inst),
		.s2_price   (s2_price),
		.s2_fill    (s2_fill),
		.s2_sum     (s2_sum),
		.s2_pn      (s2_pn)
	);

	tsoe_eval #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_eval (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.s2_valid     (s2_valid),
		.s2_ctrl      (s2_ctrl),
		.s2_inst      (s2_inst),
		.s2_price     (s2_price),
		.s2_fill      (s2_fill),
		.s2_sum       (s2_sum),
		.s2_pn        (s2_pn),
		.s2_take      (s2_take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	// an empty result register always leaves room for a new tick
	`TSOE_ASSERT_IMP(a_no_stall_when_drained, clk, arst_n, !result_valid, !tick_stall)
	// an order goes out exactly when some signal fired
	`TSOE_ASSERT_IMP(a_order_iff_signal, clk, arst_n, result_valid,
		result_data.order_valid == (result_data.threshold_hit ||
		result_data.deviation_hit || result_data.momentum_hit))
	// threshold and momentum always say buy
	`TSOE_ASSERT_IMP(a_buy_side, clk, arst_n,
		result_valid && (result_data.threshold_hit || result_data.momentum_hit),
		result_data.order_is_buy)

endmodule
